// File: sv/pwvf_pkg.sv
// Shared types, constants and register map of the presence window vote filter.
package pwvf_pkg;

  localparam int RANGE_W = 16;
  localparam int PROB_W  = 11;
  localparam int RATIO_W = 9;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int PROD_W  = 16;

  localparam int NEAR_ENTER_LEN_DEF = 16;
  localparam int NEAR_LEAVE_LEN_DEF = 32;
  localparam int MID_ENTER_LEN_DEF  = 16;
  localparam int MID_LEAVE_LEN_DEF  = 32;
  localparam int VAD_ENTER_LEN_DEF  = 8;
  localparam int VAD_LEAVE_LEN_DEF  = 16;

  localparam logic [RANGE_W-1:0] NEAR_LIMIT_MM = 16'd1200;
  localparam logic [RANGE_W-1:0] MID_LIMIT_MM  = 16'd5000;

  localparam logic [RATIO_W-1:0] RATIO_RST     = 9'd128;
  localparam logic [PROB_W-1:0]  VAD_THR_RST   = 11'd512;

  typedef enum logic [2:0] {
    REG_NEAR_ENTER = 3'd0,
    REG_NEAR_LEAVE = 3'd1,
    REG_MID_ENTER  = 3'd2,
    REG_MID_LEAVE  = 3'd3,
    REG_VAD_THR    = 3'd4,
    REG_VAD_EN     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VOTE_UNDECIDED = 2'd0,
    VOTE_YES       = 2'd1,
    VOTE_NO        = 2'd2
  } vote_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } st_t;

  typedef struct packed {
    logic push;
    logic hit;
  } zone_ctl_t;

endpackage

// File: sv/presence_window_vote_filter.sv
// Top level of the presence window vote filter: config port, control, vote and result register.
//
// Range transactions update the frame's near and mid hit flags. At acceptance, a frame-end
// transaction is pushed into the zone hit lines and, with the vote enabled and a sample
// present, into the probability cell chain; in the following evaluation cycle the running
// window counts are judged against the Q8 ratios, the probability vote is taken across the
// cell comparators and the result is loaded into the output register. The evaluation cycle
// repeats while an earlier result is still waiting at the output, and no transaction is
// taken during evaluation; in idle, range transactions are taken while a result waits.
// Histories need no clearing pass after reset.
module presence_window_vote_filter
  import pwvf_pkg::*;
#(
  parameter int NEAR_ENTER_LEN = NEAR_ENTER_LEN_DEF,
  parameter int NEAR_LEAVE_LEN = NEAR_LEAVE_LEN_DEF,
  parameter int MID_ENTER_LEN  = MID_ENTER_LEN_DEF,
  parameter int MID_LEAVE_LEN  = MID_LEAVE_LEN_DEF,
  parameter int VAD_ENTER_LEN  = VAD_ENTER_LEN_DEF,
  parameter int VAD_LEAVE_LEN  = VAD_LEAVE_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [RANGE_W-1:0] in_object_range_mm,
  input  logic [PROB_W-1:0]  in_vad_prob_q10,
  input  logic               in_vad_valid,

  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_near_present,
  output logic               out_mid_present,
  output logic               out_trusted
);

  localparam int VAD_DEPTH = (VAD_ENTER_LEN > VAD_LEAVE_LEN) ? VAD_ENTER_LEN : VAD_LEAVE_LEN;
  localparam int VFILL_W   = $clog2(VAD_DEPTH + 1);

  logic [RATIO_W-1:0] near_enter_r, near_leave_r, mid_enter_r, mid_leave_r;
  logic [PROB_W-1:0]  vad_thr_r;
  logic               vad_en_r;
  logic               cfg_wr;
  cfg_reg_t           cfg_sel;

  st_t                state_r, state_nxt;
  logic               in_acc, frame_end, commit;
  logic               fnear_r, fmid_r;
  logic               near_r, mid_r;
  vote_t              vote_r, vote_new;
  logic [VFILL_W-1:0] vfill_r;
  logic               vad_shift;
  logic               near_j, mid_j, near_f, mid_f;
  logic               out_valid_r, out_near_r, out_mid_r, out_trusted_r;
  zone_ctl_t          near_ctl, mid_ctl;

  logic [PROB_W-1:0]  vad_tap [VAD_DEPTH];
  logic [VAD_DEPTH-1:0] vad_ge, vad_gt;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_enter_r <= RATIO_RST;
      near_leave_r <= RATIO_RST;
      mid_enter_r  <= RATIO_RST;
      mid_leave_r  <= RATIO_RST;
      vad_thr_r    <= VAD_THR_RST;
      vad_en_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_NEAR_ENTER: near_enter_r <= pwdata[RATIO_W-1:0];
        REG_NEAR_LEAVE: near_leave_r <= pwdata[RATIO_W-1:0];
        REG_MID_ENTER:  mid_enter_r  <= pwdata[RATIO_W-1:0];
        REG_MID_LEAVE:  mid_leave_r  <= pwdata[RATIO_W-1:0];
        REG_VAD_THR:    vad_thr_r    <= pwdata[PROB_W-1:0];
        REG_VAD_EN:     vad_en_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_NEAR_ENTER: prdata = DATA_W'(near_enter_r);
      REG_NEAR_LEAVE: prdata = DATA_W'(near_leave_r);
      REG_MID_ENTER:  prdata = DATA_W'(mid_enter_r);
      REG_MID_LEAVE:  prdata = DATA_W'(mid_leave_r);
      REG_VAD_THR:    prdata = DATA_W'(vad_thr_r);
      REG_VAD_EN:     prdata = DATA_W'(vad_en_r);
      default:        prdata = '0;
    endcase
  end

  // control
  assign in_acc    = in_valid & ~in_stall;
  assign frame_end = in_acc & in_kind;

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b0;
    commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_kind) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        in_stall = 1'b1;
        if (!(out_valid_r && out_stall)) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // frame hit flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fnear_r <= 1'b0;
      fmid_r  <= 1'b0;
    end else if (frame_end) begin
      fnear_r <= 1'b0;
      fmid_r  <= 1'b0;
    end else if (in_acc) begin
      if (in_object_range_mm < NEAR_LIMIT_MM) begin
        fnear_r <= 1'b1;
      end else if (in_object_range_mm < MID_LIMIT_MM) begin
        fmid_r <= 1'b1;
      end
    end
  end

  // zone history lines
  assign near_ctl = '{push: frame_end, hit: fnear_r};
  assign mid_ctl  = '{push: frame_end, hit: fmid_r};

  pwvf_zone #(
    .ENTER_LEN (NEAR_ENTER_LEN),
    .LEAVE_LEN (NEAR_LEAVE_LEN)
  ) u_near (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (near_ctl),
    .hit_ratio   (near_enter_r),
    .miss_ratio  (near_leave_r),
    .cur_st      (near_r),
    .judged_st   (near_j)
  );

  pwvf_zone #(
    .ENTER_LEN (MID_ENTER_LEN),
    .LEAVE_LEN (MID_LEAVE_LEN)
  ) u_mid (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (mid_ctl),
    .hit_ratio   (mid_enter_r),
    .miss_ratio  (mid_leave_r),
    .cur_st      (mid_r),
    .judged_st   (mid_j)
  );

  // probability cell chain, newest sample in cell 0
  assign vad_shift = frame_end & vad_en_r & in_vad_valid;

  for (genvar k = 0; k < VAD_DEPTH; k++) begin : g_vad
    logic [PROB_W-1:0] d_in;
    if (k == 0) begin : g_head
      assign d_in = in_vad_prob_q10;
    end else begin : g_link
      assign d_in = vad_tap[k-1];
    end
    pwvf_vad_cell u_cell (
      .clk   (clk),
      .shift (vad_shift),
      .d_in  (d_in),
      .thr   (vad_thr_r),
      .q     (vad_tap[k]),
      .ge    (vad_ge[k]),
      .gt    (vad_gt[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vfill_r <= '0;
    end else if (vad_shift && (vfill_r < VFILL_W'(VAD_DEPTH))) begin
      vfill_r <= vfill_r + VFILL_W'(1);
    end
  end

  // activity vote
  always_comb begin
    vote_new = vote_r;
    case (vote_r)
      VOTE_YES: begin
        if ((vfill_r >= VFILL_W'(VAD_LEAVE_LEN)) && !(|vad_gt[VAD_LEAVE_LEN-1:0])) begin
          vote_new = VOTE_NO;
        end
      end
      default: begin
        if (vfill_r >= VFILL_W'(VAD_ENTER_LEN)) begin
          vote_new = (&vad_ge[VAD_ENTER_LEN-1:0]) ? VOTE_YES : VOTE_NO;
        end
      end
    endcase
    if (!vad_en_r) begin
      vote_new = vote_r;
    end
  end

  always_comb begin
    near_f = near_j;
    mid_f  = mid_j;
    if (vad_en_r) begin
      if (near_j || mid_j) begin
        if (vote_new == VOTE_NO) begin
          near_f = 1'b0;
          mid_f  = 1'b0;
        end
      end else if (vote_new == VOTE_YES) begin
        mid_f = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= 1'b0;
      mid_r  <= 1'b0;
      vote_r <= VOTE_UNDECIDED;
    end else if (commit) begin
      near_r <= near_f;
      mid_r  <= mid_f;
      vote_r <= vote_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_near_r    <= near_f;
      out_mid_r     <= mid_f;
      out_trusted_r <= (vote_new != VOTE_UNDECIDED);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_near_present = out_near_r;
  assign out_mid_present  = out_mid_r;
  assign out_trusted      = out_trusted_r;

  a_frame_end_eval: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> (state_r == ST_EVAL))
    else $error("frame end not followed by evaluation");

  a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EVAL))
    else $error("result appeared without evaluation");

  a_vote_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !vad_en_r |=> (vote_r == $past(vote_r)))
    else $error("vote changed while disabled");

  a_vote_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (vote_r != VOTE_UNDECIDED) |=> (vote_r != VOTE_UNDECIDED))
    else $error("vote returned to undecided");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !commit)
    else $error("pending result overwritten");

endmodule

// File: sv/pwvf_vad_cell.sv
// One probability history cell: holds a sample, shifts it on, compares it to the threshold.
module pwvf_vad_cell
  import pwvf_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [PROB_W-1:0] d_in,
  input  logic [PROB_W-1:0] thr,
  output logic [PROB_W-1:0] q,
  output logic              ge,
  output logic              gt
);

  logic [PROB_W-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      sample_r <= d_in;
    end
  end

  assign q  = sample_r;
  assign ge = (sample_r >= thr);
  assign gt = (sample_r > thr);

endmodule

// File: sv/pwvf_zone.sv
// Zone hit history line with running window counts and the hysteresis judge.
module pwvf_zone
  import pwvf_pkg::*;
#(
  parameter int ENTER_LEN = NEAR_ENTER_LEN_DEF,
  parameter int LEAVE_LEN = NEAR_LEAVE_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  zone_ctl_t          ctl,
  input  logic [RATIO_W-1:0] hit_ratio,
  input  logic [RATIO_W-1:0] miss_ratio,
  input  logic               cur_st,
  output logic               judged_st
);

  localparam int DEPTH  = (ENTER_LEN > LEAVE_LEN) ? ENTER_LEN : LEAVE_LEN;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int CE_W   = $clog2(ENTER_LEN + 1);
  localparam int CL_W   = $clog2(LEAVE_LEN + 1);

  logic [DEPTH-1:0]  hist_r, hist_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CE_W-1:0]   cnt_e_r, cnt_e_nxt;
  logic [CL_W-1:0]   cnt_l_r, cnt_l_nxt;
  logic              drop_e, drop_l;
  logic              full_e, full_l;
  logic [CL_W-1:0]   misses;
  logic [PROD_W-1:0] enter_lhs, enter_rhs, leave_lhs, leave_rhs;

  // newest entry at index 0
  assign hist_nxt[0] = ctl.hit;
  for (genvar k = 1; k < DEPTH; k++) begin : g_tap
    assign hist_nxt[k] = hist_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      hist_r <= hist_nxt;
    end
  end

  assign full_e = (fill_r >= FILL_W'(ENTER_LEN));
  assign full_l = (fill_r >= FILL_W'(LEAVE_LEN));
  assign drop_e = full_e & hist_r[ENTER_LEN-1];
  assign drop_l = full_l & hist_r[LEAVE_LEN-1];

  always_comb begin
    fill_nxt  = fill_r;
    cnt_e_nxt = cnt_e_r;
    cnt_l_nxt = cnt_l_r;
    if (ctl.push) begin
      if (fill_r < FILL_W'(DEPTH)) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
      cnt_e_nxt = cnt_e_r + CE_W'(ctl.hit) - CE_W'(drop_e);
      cnt_l_nxt = cnt_l_r + CL_W'(ctl.hit) - CL_W'(drop_l);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      cnt_e_r <= '0;
      cnt_l_r <= '0;
    end else begin
      fill_r  <= fill_nxt;
      cnt_e_r <= cnt_e_nxt;
      cnt_l_r <= cnt_l_nxt;
    end
  end

  assign misses    = CL_W'(LEAVE_LEN) - cnt_l_r;
  assign enter_lhs = PROD_W'({cnt_e_r, 8'h00});
  assign leave_lhs = PROD_W'({misses, 8'h00});
  assign enter_rhs = PROD_W'(hit_ratio) * PROD_W'(ENTER_LEN);
  assign leave_rhs = PROD_W'(miss_ratio) * PROD_W'(LEAVE_LEN);

  always_comb begin
    if (cur_st) begin
      judged_st = !(full_l && (leave_lhs > leave_rhs));
    end else begin
      judged_st = full_e && (enter_lhs > enter_rhs);
    end
  end

endmodule

// File: test/pwvf_checker.sv
// Checker for the presence window vote filter: tracks config writes, predicts frame results, compares.
`timescale 1ns / 1ps

module pwvf_checker
  import pwvf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               pready,

  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_kind,
  input  logic [RANGE_W-1:0] in_object_range_mm,
  input  logic [PROB_W-1:0]  in_vad_prob_q10,
  input  logic               in_vad_valid,

  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_near_present,
  input  logic               out_mid_present,
  input  logic               out_trusted,

  output int                 mismatches,
  output int                 pending
);

  localparam int NEAR_DEPTH = (NEAR_ENTER_LEN_DEF > NEAR_LEAVE_LEN_DEF) ?
                              NEAR_ENTER_LEN_DEF : NEAR_LEAVE_LEN_DEF;
  localparam int MID_DEPTH  = (MID_ENTER_LEN_DEF > MID_LEAVE_LEN_DEF) ?
                              MID_ENTER_LEN_DEF : MID_LEAVE_LEN_DEF;
  localparam int VAD_DEPTH  = (VAD_ENTER_LEN_DEF > VAD_LEAVE_LEN_DEF) ?
                              VAD_ENTER_LEN_DEF : VAD_LEAVE_LEN_DEF;

  typedef struct packed {
    logic near;
    logic mid;
    logic trusted;
  } presence_t;

  presence_t expected_q[$];

  logic [RATIO_W-1:0] near_enter_r, near_leave_r, mid_enter_r, mid_leave_r;
  logic [PROB_W-1:0]  vad_thr_r;
  logic               vad_en_r;

  logic [63:0]        near_bits, mid_bits;   // bit 0 is the newest frame
  int                 near_cnt, mid_cnt, vad_cnt;
  logic [PROB_W-1:0]  vad_samples [VAD_DEPTH];
  logic               near_on, mid_on;
  logic               near_seen, mid_seen;
  vote_t              vote_r;

  task automatic reset_model();
    near_enter_r = RATIO_RST;
    near_leave_r = RATIO_RST;
    mid_enter_r  = RATIO_RST;
    mid_leave_r  = RATIO_RST;
    vad_thr_r    = VAD_THR_RST;
    vad_en_r     = 1'b0;
    near_bits    = '0;
    mid_bits     = '0;
    near_cnt     = 0;
    mid_cnt      = 0;
    vad_cnt      = 0;
    for (int k = 0; k < VAD_DEPTH; k++) vad_samples[k] = '0;
    near_on      = 1'b0;
    mid_on       = 1'b0;
    near_seen    = 1'b0;
    mid_seen     = 1'b0;
    vote_r       = VOTE_UNDECIDED;
    expected_q.delete();
  endtask

  // Hysteresis: count misses over the leave window while on, hits over the enter window while off.
  function automatic logic zone_next(logic [63:0] bits, int fill, logic on, int enter_len,
                                     int leave_len, logic [RATIO_W-1:0] hit_ratio,
                                     logic [RATIO_W-1:0] miss_ratio);
    int cnt;
    cnt = 0;
    if (on) begin
      if (fill >= leave_len) begin
        for (int k = 0; k < leave_len; k++) if (!bits[k]) cnt++;
        if (cnt * 256 > int'(miss_ratio) * leave_len) return 1'b0;
      end
    end else if (fill >= enter_len) begin
      for (int k = 0; k < enter_len; k++) if (bits[k]) cnt++;
      if (cnt * 256 > int'(hit_ratio) * enter_len) return 1'b1;
    end
    return on;
  endfunction

  function automatic vote_t next_vote();
    logic  hit;
    vote_t v;
    v = vote_r;
    if (vote_r == VOTE_YES) begin
      if (vad_cnt >= VAD_LEAVE_LEN_DEF) begin
        hit = 1'b0;
        for (int k = 0; k < VAD_LEAVE_LEN_DEF; k++) if (vad_samples[k] > vad_thr_r) hit = 1'b1;
        if (!hit) v = VOTE_NO;
      end
    end else if (vad_cnt >= VAD_ENTER_LEN_DEF) begin
      hit = 1'b1;
      for (int k = 0; k < VAD_ENTER_LEN_DEF; k++) if (vad_samples[k] < vad_thr_r) hit = 1'b0;
      if (hit) v = VOTE_YES;
      else v = VOTE_NO;
    end
    return v;
  endfunction

  task automatic close_frame(input logic has_sample, input logic [PROB_W-1:0] prob);
    presence_t res;
    near_bits = {near_bits[62:0], near_seen};
    mid_bits  = {mid_bits[62:0], mid_seen};
    if (near_cnt < NEAR_DEPTH) near_cnt++;
    if (mid_cnt < MID_DEPTH) mid_cnt++;
    near_seen = 1'b0;
    mid_seen  = 1'b0;
    near_on = zone_next(near_bits, near_cnt, near_on, NEAR_ENTER_LEN_DEF, NEAR_LEAVE_LEN_DEF,
                        near_enter_r, near_leave_r);
    mid_on  = zone_next(mid_bits, mid_cnt, mid_on, MID_ENTER_LEN_DEF, MID_LEAVE_LEN_DEF,
                        mid_enter_r, mid_leave_r);
    if (vad_en_r) begin
      if (has_sample) begin
        for (int k = VAD_DEPTH - 1; k > 0; k--) vad_samples[k] = vad_samples[k-1];
        vad_samples[0] = prob;
        if (vad_cnt < VAD_DEPTH) vad_cnt++;
      end
      vote_r = next_vote();
      if (near_on || mid_on) begin
        if (vote_r == VOTE_NO) begin
          near_on = 1'b0;
          mid_on  = 1'b0;
        end
      end else if (vote_r == VOTE_YES) begin
        mid_on = 1'b1;
      end
    end
    res.near    = near_on;
    res.mid     = mid_on;
    res.trusted = (vote_r != VOTE_UNDECIDED);
    expected_q.push_back(res);
  endtask

  task automatic check_result();
    presence_t exp_r;
    if (expected_q.size() == 0) begin
      $error("unexpected result transaction: near_present=%0b mid_present=%0b trusted=%0b",
             out_near_present, out_mid_present, out_trusted);
      mismatches++;
    end else begin
      exp_r = expected_q.pop_front();
      if (out_near_present !== exp_r.near) begin
        $error("near_present: expected %0b, got %0b", exp_r.near, out_near_present);
        mismatches++;
      end
      if (out_mid_present !== exp_r.mid) begin
        $error("mid_present: expected %0b, got %0b", exp_r.mid, out_mid_present);
        mismatches++;
      end
      if (out_trusted !== exp_r.trusted) begin
        $error("trusted: expected %0b, got %0b", exp_r.trusted, out_trusted);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[ADDR_W-1:2]))
          REG_NEAR_ENTER: near_enter_r = pwdata[RATIO_W-1:0];
          REG_NEAR_LEAVE: near_leave_r = pwdata[RATIO_W-1:0];
          REG_MID_ENTER:  mid_enter_r  = pwdata[RATIO_W-1:0];
          REG_MID_LEAVE:  mid_leave_r  = pwdata[RATIO_W-1:0];
          REG_VAD_THR:    vad_thr_r    = pwdata[PROB_W-1:0];
          REG_VAD_EN:     vad_en_r     = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_kind) begin
          close_frame(in_vad_valid, in_vad_prob_q10);
        end else if (in_object_range_mm < NEAR_LIMIT_MM) begin
          near_seen = 1'b1;
        end else if (in_object_range_mm < MID_LIMIT_MM) begin
          mid_seen = 1'b1;
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: test/tb_presence_window_vote_filter.sv
// Testbench top for the presence window vote filter: clock, reset, stimulus, config and verdict.
`timescale 1ns / 1ps

module tb_presence_window_vote_filter;
  import pwvf_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = 1'b0;
  logic [RANGE_W-1:0] in_object_range_mm = '0;
  logic [PROB_W-1:0]  in_vad_prob_q10 = '0;
  logic               in_vad_valid = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_near_present;
  logic               out_mid_present;
  logic               out_trusted;

  int                 mismatches;
  int                 pending;
  int                 send_pct = 0;
  int                 recv_pct = 0;
  int                 hold_cnt = 0;
  logic               hold_tog = 1'b0;
  logic               hold_seen = 1'b0;

  presence_window_vote_filter u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_object_range_mm (in_object_range_mm),
    .in_vad_prob_q10    (in_vad_prob_q10),
    .in_vad_valid       (in_vad_valid),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_near_present   (out_near_present),
    .out_mid_present    (out_mid_present),
    .out_trusted        (out_trusted)
  );

  pwvf_checker u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_object_range_mm (in_object_range_mm),
    .in_vad_prob_q10    (in_vad_prob_q10),
    .in_vad_valid       (in_vad_valid),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_near_present   (out_near_present),
    .out_mid_present    (out_mid_present),
    .out_trusted        (out_trusted),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stall, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_cnt  <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  task automatic send_item(input logic kind, input logic [RANGE_W-1:0] rng,
                           input logic [PROB_W-1:0] prob, input logic has_sample);
    int   gap;
    logic stalled;
    gap = 0;
    while ($urandom_range(0, 99) < send_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_kind            <= kind;
    in_object_range_mm <= rng;
    in_vad_prob_q10    <= prob;
    in_vad_valid       <= has_sample;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
    logic rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every expected result, then let the block settle.
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 10;
      2: return 50;
      3: return 90;
      default: return 100;
    endcase
  endfunction

  task automatic run_phase(input int budget, input logic [RATIO_W-1:0] ner,
                           input logic [RATIO_W-1:0] nlr, input logic [RATIO_W-1:0] mer,
                           input logic [RATIO_W-1:0] mlr, input logic [PROB_W-1:0] thr,
                           input logic en, input int s_pct, input int r_pct, input int pressure);
    int   sent;
    int   nframes;
    int   near_pct;
    int   mid_pct;
    int   n_far;
    int   thr_i;
    logic vad_hi;
    logic pressed;
    logic [RANGE_W-1:0] rng;
    logic [PROB_W-1:0]  prob;
    settle(4);
    cfg_write(REG_NEAR_ENTER, DATA_W'(ner));
    cfg_write(REG_NEAR_LEAVE, DATA_W'(nlr));
    cfg_write(REG_MID_ENTER, DATA_W'(mer));
    cfg_write(REG_MID_LEAVE, DATA_W'(mlr));
    cfg_write(REG_VAD_THR, DATA_W'(thr));
    cfg_write(REG_VAD_EN, DATA_W'(en));
    thr_i    = int'(thr);
    send_pct = s_pct;
    recv_pct = r_pct;
    sent     = 0;
    pressed  = 1'b0;
    while (sent < budget) begin
      nframes  = $urandom_range(4, 40);
      near_pct = pick_pct();
      mid_pct  = pick_pct();
      vad_hi   = 1'($urandom_range(0, 1));
      for (int f = 0; f < nframes && sent < budget; f++) begin
        if (!pressed && sent >= budget / 2) begin
          pressed = 1'b1;
          if (pressure == 1) hold_tog <= ~hold_tog;
          else if (pressure == 2) settle(0);
        end
        if ($urandom_range(0, 99) < near_pct) begin
          rng = ($urandom_range(0, 9) == 0) ? 16'd1199 : RANGE_W'($urandom_range(0, 1199));
          send_item(1'b0, rng, PROB_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
          sent++;
        end
        n_far = $urandom_range(0, 2);
        for (int j = 0; j < n_far; j++) begin
          case ($urandom_range(0, 9))
            0: rng = MID_LIMIT_MM;
            1, 2: rng = RANGE_W'($urandom_range(0, 65535));
            default: rng = RANGE_W'($urandom_range(5000, 65535));
          endcase
          send_item(1'b0, rng, PROB_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
          sent++;
        end
        if ($urandom_range(0, 99) < mid_pct) begin
          case ($urandom_range(0, 9))
            0: rng = NEAR_LIMIT_MM;
            1: rng = 16'd4999;
            default: rng = RANGE_W'($urandom_range(1200, 4999));
          endcase
          send_item(1'b0, rng, PROB_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
          sent++;
        end
        if ($urandom_range(0, 6) == 0) prob = PROB_W'($urandom_range(0, 2047));
        else if (vad_hi)
          prob = PROB_W'($urandom_range(thr_i, (thr_i > 1847) ? 2047 : thr_i + 200));
        else prob = PROB_W'($urandom_range((thr_i < 200) ? 0 : thr_i - 200, thr_i));
        send_item(1'b1, RANGE_W'($urandom_range(0, 65535)), prob, $urandom_range(0, 9) != 0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zone boundaries, empty frames, extreme probabilities, vote still disabled
    send_item(1'b0, 16'd0, 11'd0, 1'b0);
    send_item(1'b0, 16'hFFFF, 11'h7FF, 1'b1);
    send_item(1'b1, 16'hFFFF, 11'd0, 1'b0);
    send_item(1'b0, 16'd1199, 11'd0, 1'b0);
    send_item(1'b1, 16'd0, 11'h7FF, 1'b1);
    send_item(1'b0, 16'd1200, 11'd0, 1'b0);
    send_item(1'b1, 16'd0, 11'd1024, 1'b1);
    send_item(1'b0, 16'd4999, 11'd0, 1'b0);
    send_item(1'b1, 16'd0, 11'd512, 1'b1);
    send_item(1'b0, 16'd5000, 11'd0, 1'b0);
    send_item(1'b1, 16'd0, 11'd0, 1'b1);
    send_item(1'b1, 16'hFFFF, 11'h7FF, 1'b1);
    send_item(1'b0, 16'd1199, 11'h7FF, 1'b1);
    send_item(1'b0, 16'd4999, 11'h7FF, 1'b1);
    send_item(1'b0, 16'hFFFF, 11'h7FF, 1'b1);
    send_item(1'b1, 16'h5555, 11'd511, 1'b0);

    run_phase(200, 9'd128, 9'd128, 9'd128, 9'd128, 11'd512, 1'b1, 0, 0, 1);
    run_phase(200, 9'd0, 9'd0, 9'd0, 9'd0, 11'd0, 1'b1, 51, 0, 2);
    run_phase(200, 9'd256, 9'd256, 9'd256, 9'd256, 11'd1024, 1'b1, 0, 51, 0);
    run_phase(200, 9'd64, 9'd200, 9'd32, 9'd255, 11'd300, 1'b0, 7, 7, 0);
    run_phase(200, RATIO_W'($urandom_range(0, 511)), RATIO_W'($urandom_range(0, 511)),
              RATIO_W'($urandom_range(0, 511)), RATIO_W'($urandom_range(0, 511)),
              PROB_W'($urandom_range(0, 2047)), 1'b1, 7, 7, 0);
    run_phase(200, 9'd511, 9'd0, 9'd255, 9'd1, 11'd2047, 1'b1, 0, 0, 0);
    run_phase(200, 9'd100, 9'd100, 9'd160, 9'd60, 11'd700, 1'b1, 51, 51, 0);

    settle(20);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
